FILE: sv/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define AST_HOLDS(lbl, clk, rst_n, prop)
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/fxa_pkg.sv
`default_nettype none
package fxa_pkg;
    localparam logic [3:0] MODE_ADD    = 4'd0;
    localparam logic [3:0] MODE_SUB    = 4'd1;
    localparam logic [3:0] MODE_MUL    = 4'd2;
    localparam logic [3:0] MODE_DIV    = 4'd3;
    localparam logic [3:0] MODE_GT     = 4'd4;
    localparam logic [3:0] MODE_LT     = 4'd5;
    localparam logic [3:0] MODE_GE     = 4'd6;
    localparam logic [3:0] MODE_LE     = 4'd7;
    localparam logic [3:0] MODE_EQ     = 4'd8;
    localparam logic [3:0] MODE_NE     = 4'd9;
    localparam logic [3:0] MODE_TO_INT = 4'd10;

    // per-stage control that moves with each request
    typedef struct packed {
        logic       valid;
        logic [3:0] mode;
        logic       neg;
        logic       dz;
        logic       cmp;
    } t_ctl;
endpackage
`default_nettype wire

FILE: sv/fxa_req_if.sv
`default_nettype none
interface fxa_req_if #(parameter int WORD_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic [3:0]                   mode;
    logic signed [WORD_WIDTH-1:0] operand_a;
    logic signed [WORD_WIDTH-1:0] operand_b;
    modport source (output valid, mode, operand_a, operand_b, input ready);
    modport sink   (input valid, mode, operand_a, operand_b, output ready);
    modport monitor (input valid, ready, mode, operand_a, operand_b);
endinterface
`default_nettype wire

FILE: sv/fxa_rsp_if.sv
`default_nettype none
interface fxa_rsp_if #(parameter int WORD_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] result_value;
    logic                         compare_true;
    logic                         divide_by_zero;
    modport source (output valid, result_value, compare_true, divide_by_zero, input ready);
    modport sink   (input valid, result_value, compare_true, divide_by_zero, output ready);
    modport monitor (input valid, ready, result_value, compare_true, divide_by_zero);
endinterface
`default_nettype wire

FILE: sv/fxa_div_cell.sv
`default_nettype none
module fxa_div_cell #(
    parameter int WORD_WIDTH    = 32,
    parameter int FRACTION_BITS = 8
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  fxa_pkg::t_ctl                      i_ctl,
    input  wire  [WORD_WIDTH-1:0]              i_rem,
    input  wire  [WORD_WIDTH+FRACTION_BITS-1:0] i_num,
    input  wire  [WORD_WIDTH-1:0]              i_quo,
    input  wire  [WORD_WIDTH-1:0]              i_val,
    input  wire  [WORD_WIDTH-1:0]              i_den,
    input  wire                                i_adv_next,
    output wire                                o_adv,
    output fxa_pkg::t_ctl                      o_ctl,
    output logic [WORD_WIDTH-1:0]              o_rem,
    output logic [WORD_WIDTH+FRACTION_BITS-1:0] o_num,
    output logic [WORD_WIDTH-1:0]              o_quo,
    output logic [WORD_WIDTH-1:0]              o_val,
    output logic [WORD_WIDTH-1:0]              o_den
);
    import fxa_pkg::*;
    localparam int NW = WORD_WIDTH + FRACTION_BITS;

    t_ctl                r_ctl;
    logic [WORD_WIDTH:0] w_trial;
    logic [WORD_WIDTH:0] w_diff;
    logic                w_fit;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign w_trial = {i_rem, i_num[NW-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_fit   = w_trial >= {1'b0, i_den};
    assign o_adv   = !r_ctl.valid || i_adv_next;
    assign o_ctl   = r_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            o_rem <= w_fit ? w_diff[WORD_WIDTH-1:0] : w_trial[WORD_WIDTH-1:0];
            o_num <= {i_num[NW-2:0], 1'b0};
            o_quo <= {i_quo[WORD_WIDTH-2:0], w_fit};
            o_val <= i_val;
            o_den <= i_den;
        end
    end
endmodule
`default_nettype wire

FILE: sv/fixed_point_q24_8_alu.sv
`default_nettype none
// signed fixed-point alu, q24.8 at the default parameters. one request in, one
// response out, no state kept between requests. add and sub wrap; mul takes the
// exact double-width product of the magnitudes, drops the fraction bits
// (truncating toward zero) and wraps; div forms (a << FRACTION_BITS) / b,
// truncated toward zero and wrapped, and a zero divisor returns 0 with
// divide_by_zero set; the six compares return 0 in result_value; to_int is an
// arithmetic shift right. a new request is taken every cycle while the front
// stage can move; each one passes through one front stage, a row of
// WORD_WIDTH + FRACTION_BITS divider cells that each settle one quotient bit,
// and the output register. every operation walks the same row so responses
// leave in request order. stalls pack bubbles out of the row, so the input
// keeps taking requests while a response waits, until the row is full.
`include "assert_macros.svh"
module fixed_point_q24_8_alu #(
    parameter int WORD_WIDTH    = 32,
    parameter int FRACTION_BITS = 8
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    fxa_req_if.sink   i_req,
    fxa_rsp_if.source o_rsp
);
    import fxa_pkg::*;
    localparam int NW     = WORD_WIDTH + FRACTION_BITS;
    localparam int NCELLS = NW;

    // front stage
    t_ctl                  r_ctl0, n_ctl0;
    logic [WORD_WIDTH-1:0] r_val0, n_val0;
    logic [WORD_WIDTH-1:0] r_den0;
    logic [NW-1:0]         r_num0;
    logic [WORD_WIDTH-1:0] w_ma, w_mb;
    logic [2*WORD_WIDTH-1:0] w_prod;
    logic                  w_adv0;

    // cell row links
    t_ctl                  c_ctl [NCELLS+1];
    logic [WORD_WIDTH-1:0] c_rem [NCELLS+1];
    logic [NW-1:0]         c_num [NCELLS+1];
    logic [WORD_WIDTH-1:0] c_quo [NCELLS+1];
    logic [WORD_WIDTH-1:0] c_val [NCELLS+1];
    logic [WORD_WIDTH-1:0] c_den [NCELLS+1];
    logic                  c_adv [NCELLS+1];

    // output register
    t_ctl                  r_out_ctl;
    logic [WORD_WIDTH-1:0] r_out_val, n_out_val;
    logic                  w_adv_out;

    assign w_ma   = i_req.operand_a[WORD_WIDTH-1] ? -i_req.operand_a : i_req.operand_a;
    assign w_mb   = i_req.operand_b[WORD_WIDTH-1] ? -i_req.operand_b : i_req.operand_b;
    assign w_prod = {{WORD_WIDTH{1'b0}}, w_ma} * {{WORD_WIDTH{1'b0}}, w_mb};

    always_comb begin
        n_ctl0       = '0;
        n_ctl0.valid = i_req.valid;
        n_ctl0.mode  = i_req.mode;
        n_ctl0.neg   = i_req.operand_a[WORD_WIDTH-1] ^ i_req.operand_b[WORD_WIDTH-1];
        n_ctl0.dz    = (i_req.mode == MODE_DIV) && (i_req.operand_b == '0);
        n_val0       = '0;
        case (i_req.mode)
            MODE_ADD:    n_val0 = i_req.operand_a + i_req.operand_b;
            MODE_SUB:    n_val0 = i_req.operand_a - i_req.operand_b;
            MODE_MUL:    n_val0 = w_prod[FRACTION_BITS+WORD_WIDTH-1:FRACTION_BITS];
            MODE_GT:     n_ctl0.cmp = i_req.operand_a >  i_req.operand_b;
            MODE_LT:     n_ctl0.cmp = i_req.operand_a <  i_req.operand_b;
            MODE_GE:     n_ctl0.cmp = i_req.operand_a >= i_req.operand_b;
            MODE_LE:     n_ctl0.cmp = i_req.operand_a <= i_req.operand_b;
            MODE_EQ:     n_ctl0.cmp = i_req.operand_a == i_req.operand_b;
            MODE_NE:     n_ctl0.cmp = i_req.operand_a != i_req.operand_b;
            MODE_TO_INT: n_val0 = i_req.operand_a >>> FRACTION_BITS;
            default:     n_val0 = '0;
        endcase
    end

    // a slot moves when it is empty or the cell behind it moves
    assign w_adv0      = !r_ctl0.valid || c_adv[0];
    assign i_req.ready = w_adv0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (w_adv0) begin
            r_ctl0 <= n_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv0) begin
            r_val0 <= n_val0;
            r_den0 <= w_mb;
            r_num0 <= {w_ma, {FRACTION_BITS{1'b0}}};
        end
    end

    assign c_ctl[0] = r_ctl0;
    assign c_rem[0] = '0;
    assign c_num[0] = r_num0;
    assign c_quo[0] = '0;
    assign c_val[0] = r_val0;
    assign c_den[0] = r_den0;
    assign c_adv[NCELLS] = w_adv_out;

    // divider row, one quotient bit per cell, msb first
    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        fxa_div_cell #(
            .WORD_WIDTH    (WORD_WIDTH),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (c_ctl[g]),
            .i_rem      (c_rem[g]),
            .i_num      (c_num[g]),
            .i_quo      (c_quo[g]),
            .i_val      (c_val[g]),
            .i_den      (c_den[g]),
            .i_adv_next (c_adv[g+1]),
            .o_adv      (c_adv[g]),
            .o_ctl      (c_ctl[g+1]),
            .o_rem      (c_rem[g+1]),
            .o_num      (c_num[g+1]),
            .o_quo      (c_quo[g+1]),
            .o_val      (c_val[g+1]),
            .o_den      (c_den[g+1])
        );
    end

    // sign fix-up for mul and div, zero for a zero divisor
    always_comb begin
        case (c_ctl[NCELLS].mode)
            MODE_MUL: n_out_val = c_ctl[NCELLS].neg ? -c_val[NCELLS] : c_val[NCELLS];
            MODE_DIV: begin
                if (c_ctl[NCELLS].dz) begin
                    n_out_val = '0;
                end else begin
                    n_out_val = c_ctl[NCELLS].neg ? -c_quo[NCELLS] : c_quo[NCELLS];
                end
            end
            default:  n_out_val = c_val[NCELLS];
        endcase
    end

    assign w_adv_out = !r_out_ctl.valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ctl <= '0;
        end else if (w_adv_out) begin
            r_out_ctl <= c_ctl[NCELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_out) begin
            r_out_val <= n_out_val;
        end
    end

    assign o_rsp.valid          = r_out_ctl.valid;
    assign o_rsp.result_value   = r_out_val;
    assign o_rsp.compare_true   = r_out_ctl.cmp;
    assign o_rsp.divide_by_zero = r_out_ctl.dz;

    `AST_IMPLIES(a_dz_only_div, i_clk, i_rst_n, r_out_ctl.valid && r_out_ctl.dz,
        r_out_ctl.mode == MODE_DIV && r_out_val == '0)
    `AST_IMPLIES(a_cmp_zero_val, i_clk, i_rst_n, r_out_ctl.valid && r_out_ctl.cmp,
        r_out_val == '0 && r_out_ctl.mode >= MODE_GT && r_out_ctl.mode <= MODE_NE)
    `AST_IMPLIES(a_stall_holds_front, i_clk, i_rst_n, r_ctl0.valid && !c_adv[0],
        ##1 r_ctl0.valid && $stable(r_num0) && $stable(r_val0))
endmodule
`default_nettype wire
